/* sv/mr90_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mr90_pkg: shared types and constants of the 90-degree matrix rotator
// Holds the result queue sizing, the size register layout and the structs
// that pass between the front, the store and the result queue.
// ----------------------------------------------------------------------------
package mr90_pkg;

	// Size register layout and its value after reset.
	localparam int CFG_SIZE_W     = 6;
	localparam int CFG_SIZE_RESET = 32;

	// Width of one result element on the output stream.
	localparam int OUT_W = 32;

	// Result queue between the store read and the output stream.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// Read request issued by the front, registered alongside the read data.
	typedef struct packed {
		logic valid;
		logic frame_end;
	} rd_req_t;

	// One queued result item.
	typedef struct packed {
		logic             frame_end;
		logic [OUT_W-1:0] value;
	} q_entry_t;

endpackage

/* sv/matrix_rotate_90_cw.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_rotate_90_cw: streaming 90-degree clockwise matrix rotator
// Ping-pong frame store with a decoupled input front and output queue.
// ----------------------------------------------------------------------------
// Elements of an N by N matrix enter one item per clock while s_tready is
// high, in row-major order, into one bank of a two-bank store while the
// previous frame is read out of the other bank in clockwise-rotated row-major
// order, one result per accepted element, with m_tlast on the last element
// of a frame. The block sustains one item per cycle while the queue has room,
// the store doing one write and one read each cycle. The first frame after
// reset or after a size write yields no results. A four-item result queue
// keeps s_tready high through short output stalls; it drops only when the
// queue plus the read in flight is full. A size write restarts framing; the
// user must make it while no items are in flight; the block does not check.
// ----------------------------------------------------------------------------
module matrix_rotate_90_cw #(
	parameter int MAX_SIZE      = 32,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Size register write channel: matrix_size.
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mr90_pkg::CFG_SIZE_W-1:0]        cfg_data,
	// Input stream; s_tdata fields from bit 0: element_value.
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((ELEMENT_WIDTH + 7) / 8) * 8-1:0] s_tdata,
	// Output stream; m_tdata fields from bit 0: rotated_value. m_tlast: frame_end.
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [mr90_pkg::OUT_W-1:0]             m_tdata,
	output logic                                   m_tlast
);

	import mr90_pkg::*;

	localparam int DEPTH = 2 * MAX_SIZE * MAX_SIZE;
	localparam int AW    = $clog2(DEPTH);

	logic                          room;
	logic                          wr_en, rd_en;
	logic [AW-1:0]                 wr_addr, rd_addr;
	logic [ELEMENT_WIDTH-1:0]      wr_data, rd_data;
	logic [ELEMENT_WIDTH+OUT_W-1:0] rd_ext;
	rd_req_t                       req_s1;
	q_entry_t                      push_data, head;

	// The size register is always writable.
	assign cfg_ready = 1'b1;

	mr90_front #(
		.MAX_SIZE      (MAX_SIZE),
		.ELEMENT_WIDTH (ELEMENT_WIDTH),
		.AW            (AW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_size (cfg_data),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata[ELEMENT_WIDTH-1:0]),
		.room     (room),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.req_s1   (req_s1)
	);

	mr90_ram #(
		.WIDTH (ELEMENT_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Result value is the low output-width bits of the element, zero-filled.
	assign rd_ext              = {{OUT_W{1'b0}}, rd_data};
	assign push_data.value     = rd_ext[OUT_W-1:0];
	assign push_data.frame_end = req_s1.frame_end;

	mr90_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.pending   (req_s1.valid),
		.push_data (push_data),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (head)
	);

	assign m_tdata = head.value;
	assign m_tlast = head.frame_end;

endmodule

/* sv/mr90_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mr90_ram: generic simple dual-port RAM
// One write port and one read port, read data registered on the read enable.
// ----------------------------------------------------------------------------
module mr90_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* sv/mr90_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mr90_front: input side of the rotator
// Accepts elements, keeps the write and rotated read positions, writes the
// current bank and issues the read of the previous frame from the other bank.
// ----------------------------------------------------------------------------
module mr90_front #(
	parameter int MAX_SIZE      = 32,
	parameter int ELEMENT_WIDTH = 32,
	parameter int AW            = 11
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Size register write.
	input  logic                             cfg_we,
	input  logic [mr90_pkg::CFG_SIZE_W-1:0]  cfg_size,
	// Input stream.
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ELEMENT_WIDTH-1:0]         in_data,
	input  logic                             room,
	// Frame store ports.
	output logic                             wr_en,
	output logic [AW-1:0]                    wr_addr,
	output logic [ELEMENT_WIDTH-1:0]         wr_data,
	output logic                             rd_en,
	output logic [AW-1:0]                    rd_addr,
	// Request that travels alongside the read data.
	output mr90_pkg::rd_req_t                req_s1
);

	import mr90_pkg::*;

	localparam int IDXW      = $clog2(MAX_SIZE);
	localparam int BANK      = MAX_SIZE * MAX_SIZE;
	localparam int LAST_RST  = ((CFG_SIZE_RESET < MAX_SIZE) ? CFG_SIZE_RESET : MAX_SIZE) - 1;

	logic [IDXW-1:0] wr_row_q, wr_col_q, rd_row_q, rd_col_q, last_q;
	logic            bank_q, prev_ready_q;
	logic            accept;
	logic [8:0]      size_v;
	logic [IDXW-1:0] last_d;
	logic [IDXW-1:0] src_row;
	logic            rd_end;

	assign in_ready = room;
	assign accept   = in_valid && room;

	// Size in use: zero acts as one, large values saturate to the store side.
	always_comb begin
		size_v = {3'b000, cfg_size};
		if (size_v == 9'd0) begin
			size_v = 9'd1;
		end
		if (size_v > 9'(MAX_SIZE)) begin
			size_v = 9'(MAX_SIZE);
		end
		last_d = IDXW'(size_v - 9'd1);
	end

	// Store addresses: bank offset, row times the row pitch, column.
	assign src_row = last_q - rd_col_q;
	assign rd_end  = (rd_row_q == last_q) && (rd_col_q == last_q);
	assign wr_en   = accept;
	assign wr_data = in_data;
	assign rd_en   = accept && prev_ready_q;
	assign wr_addr = (bank_q ? AW'(BANK) : AW'(0)) + AW'(wr_row_q) * AW'(MAX_SIZE)
		+ AW'(wr_col_q);
	assign rd_addr = (bank_q ? AW'(0) : AW'(BANK)) + AW'(src_row) * AW'(MAX_SIZE)
		+ AW'(rd_row_q);

	// Position counters, bank toggle and frame-ready flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_row_q     <= '0;
			wr_col_q     <= '0;
			rd_row_q     <= '0;
			rd_col_q     <= '0;
			last_q       <= IDXW'(LAST_RST);
			bank_q       <= 1'b0;
			prev_ready_q <= 1'b0;
		end else if (cfg_we) begin
			wr_row_q     <= '0;
			wr_col_q     <= '0;
			rd_row_q     <= '0;
			rd_col_q     <= '0;
			last_q       <= last_d;
			prev_ready_q <= 1'b0;
		end else if (accept) begin
			if (prev_ready_q) begin
				if (rd_col_q == last_q) begin
					rd_col_q <= '0;
					rd_row_q <= (rd_row_q == last_q) ? '0 : rd_row_q + 1'b1;
				end else begin
					rd_col_q <= rd_col_q + 1'b1;
				end
			end
			if (wr_col_q == last_q) begin
				wr_col_q <= '0;
				if (wr_row_q == last_q) begin
					wr_row_q     <= '0;
					bank_q       <= ~bank_q;
					prev_ready_q <= 1'b1;
					rd_row_q     <= '0;
					rd_col_q     <= '0;
				end else begin
					wr_row_q <= wr_row_q + 1'b1;
				end
			end else begin
				wr_col_q <= wr_col_q + 1'b1;
			end
		end
	end

	// Read request stage, aligned with the registered store output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else begin
			req_s1.valid     <= rd_en;
			req_s1.frame_end <= rd_end;
		end
	end

endmodule

/* sv/mr90_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mr90_queue: result queue and output stream side
// Buffers read results so the input keeps flowing while the output stalls,
// and tells the front whether a new read still has a free slot.
// ----------------------------------------------------------------------------
module mr90_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pending,
	input  mr90_pkg::q_entry_t  push_data,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output mr90_pkg::q_entry_t  out_data
);

	import mr90_pkg::*;

	q_entry_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wptr_q, rptr_q;
	logic [QCNT_W-1:0]     count_q;
	logic                  pop;
	logic [QCNT_W:0]       used;

	assign out_valid = (count_q != '0);
	assign out_data  = slot_q[rptr_q];
	assign pop       = out_valid && out_ready;

	// Count the read in flight as taken so its result always finds a slot.
	assign used = {1'b0, count_q} + (QCNT_W + 1)'(pending);
	assign room = used < (QCNT_W + 1)'(QUEUE_DEPTH);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (pending) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (pending) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({pending, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* sv/mr90_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mr90_checker: port-level checks for the matrix rotator
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module mr90_checker #(
	parameter int ELEMENT_WIDTH = 32
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_tvalid,
	input logic                                   s_tready,
	input logic [((ELEMENT_WIDTH + 7) / 8) * 8-1:0] s_tdata,
	input logic                                   m_tvalid,
	input logic                                   m_tready,
	input logic [mr90_pkg::OUT_W-1:0]             m_tdata,
	input logic                                   m_tlast
);

	// A stalled input item stays offered with the same element.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("input item changed while stalled");

	// A stalled result item holds its value and its frame flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result item changed while stalled");

	// No result is pending right after reset.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result shown right after reset");

	// A result appears only after an accepted input item, via store and queue.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result item without an input item two cycles before");

endmodule

bind matrix_rotate_90_cw mr90_checker #(
	.ELEMENT_WIDTH (ELEMENT_WIDTH)
) u_mr90_checker (.*);

/* dv/matrix_rotate_90_cw_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_rotate_90_cw_tb: self-checking bench for the clockwise matrix rotator
// Streams element frames of many sizes into the rotator. For every accepted
// item, a local model of the ping-pong store, or a directed row, gives the
// rotated item of the previous frame that should come out. Output items are
// compared in order while the sender pauses between random bursts and the
// receiver stalls.
// ----------------------------------------------------------------------------
module matrix_rotate_90_cw_tb;
	import mr90_pkg::*;

	localparam int SIDE_MAX       = 32;
	localparam int BANK_WORDS     = SIDE_MAX * SIDE_MAX;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 400;
	// The directed table yields ten results, so the hold starts in the pressure phase.
	localparam int HOLD_TRIGGER   = 12;
	localparam int IDLE_LIMIT     = 2000;
	localparam int REPORT_MAX     = 10;
	localparam int RANDOM_ITEMS   = 425;

	typedef logic [OUT_W-1:0] word_t;
	typedef enum logic {ROW_SIZE, ROW_ELEM} row_kind_e;
	typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_e;

	typedef struct packed {
		word_t value;
		logic  frame_end;
	} rot_item_t;

	typedef struct packed {
		row_kind_e kind;
		word_t     data;
		logic      typed;
		logic      has_result;
		rot_item_t result;
	} dir_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_SIZE_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	// Fields from bit 0: element_value.
	logic [31:0]           s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// Fields from bit 0: rotated_value.
	logic [OUT_W-1:0]      m_tdata;
	logic                  m_tlast;

	// Local copy of the rotator state.
	word_t                 frame_copy [2 * BANK_WORDS];
	int unsigned           wr_row     = 0;
	int unsigned           wr_col     = 0;
	int unsigned           rd_row     = 0;
	int unsigned           rd_col     = 0;
	logic                  wr_bank    = 1'b0;
	logic                  frame_held = 1'b0;
	logic [CFG_SIZE_W-1:0] size_reg   = CFG_SIZE_W'(CFG_SIZE_RESET);

	rot_item_t   rotations_due [$];
	dir_row_t    dir_rows [$];
	int unsigned mismatches   = 0;
	int unsigned results_seen = 0;
	int unsigned random_items = 0;
	int          burst_left   = 1;
	int unsigned idle_cycles  = 0;
	logic        held_off     = 1'b0;

	matrix_rotate_90_cw u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Side length in use for a size value: zero acts as one, large values saturate.
	function automatic int unsigned size_side(input logic [CFG_SIZE_W-1:0] sz);
		if (sz == 0) return 1;
		if (sz > SIDE_MAX) return SIDE_MAX;
		return sz;
	endfunction

	function automatic int unsigned store_index(input logic bank, input int unsigned row,
			input int unsigned col);
		return (bank ? BANK_WORDS : 0) + row * SIDE_MAX + col;
	endfunction

	// Stores one element and returns the rotated item of the previous frame, if any.
	function automatic logic rotate_step(input word_t elem, output rot_item_t res);
		int unsigned last;
		logic        made;
		last = size_side(size_reg) - 1;
		made = 1'b0;
		res  = '0;
		if (frame_held) begin
			res.value     = frame_copy[store_index(!wr_bank, last - rd_col, rd_row)];
			res.frame_end = (rd_row == last) && (rd_col == last);
			made          = 1'b1;
			if (rd_col == last) begin
				rd_col = 0;
				rd_row = (rd_row == last) ? 0 : rd_row + 1;
			end else begin
				rd_col++;
			end
		end
		frame_copy[store_index(wr_bank, wr_row, wr_col)] = elem;
		if (wr_col == last) begin
			wr_col = 0;
			if (wr_row == last) begin
				wr_row     = 0;
				wr_bank    = !wr_bank;
				frame_held = 1'b1;
				rd_row     = 0;
				rd_col     = 0;
			end else begin
				wr_row++;
			end
		end else begin
			wr_col++;
		end
		return made;
	endfunction

	function automatic dir_row_t make_row(input row_kind_e kind, input word_t data,
			input logic typed, input logic has_result, input word_t value,
			input logic frame_end);
		dir_row_t row;
		row.kind       = kind;
		row.data       = data;
		row.typed      = typed;
		row.has_result = has_result;
		row.result     = '{value, frame_end};
		return row;
	endfunction

	function automatic word_t random_element();
		case ($urandom_range(0, 15))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	task automatic note_mismatch(input string what, input rot_item_t want,
			input rot_item_t got);
		if (mismatches < REPORT_MAX)
			$display("%0t: %s: expected value %h end %b, got value %h end %b",
				$realtime, what, want.value, want.frame_end, got.value, got.frame_end);
		mismatches++;
	endtask

	// Offers one item and, once it is accepted, queues what should come out.
	task automatic send_element(input word_t elem, input logic typed,
			input logic has_result, input rot_item_t typed_res);
		rot_item_t res;
		logic      made;
		s_tvalid <= 1'b1;
		s_tdata  <= elem;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		made = rotate_step(elem, res);
		if (typed) begin
			if (has_result) rotations_due.push_back(typed_res);
		end else if (made) begin
			rotations_due.push_back(res);
		end
	endtask

	// Ends a burst with a random gap once its length runs out.
	task automatic pace_sender();
		burst_left--;
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 16);
		end
	endtask

	// Writes the size once all results are out and the pipeline has settled.
	task automatic write_size(input logic [CFG_SIZE_W-1:0] sz);
		s_tvalid <= 1'b0;
		while (rotations_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= sz;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid  <= 1'b0;
		size_reg   = sz;
		wr_row     = 0;
		wr_col     = 0;
		rd_row     = 0;
		rd_col     = 0;
		frame_held = 1'b0;
	endtask

	task automatic run_phase(input logic [CFG_SIZE_W-1:0] sz, input int unsigned items,
			input logic counted);
		write_size(sz);
		for (int unsigned k = 0; k < items; k++) begin
			send_element(random_element(), 1'b0, 1'b0, '0);
			if (counted) random_items++;
			if (k + 1 < items) pace_sender();
		end
	endtask

	// Main stimulus: directed table, pressure and saturation phases, then random phases.
	initial begin : stimulus
		dir_row_t              row;
		logic [CFG_SIZE_W-1:0] sz;
		int unsigned           n;
		int unsigned           items;

		// Size one: every item after the first returns the one before it, each ending a frame.
		dir_rows.push_back(make_row(ROW_SIZE, 32'd1, 1'b0, 1'b0, '0, 1'b0));
		dir_rows.push_back(make_row(ROW_ELEM, 32'h7FFF_FFFF, 1'b1, 1'b0, '0, 1'b0));
		dir_rows.push_back(make_row(ROW_ELEM, 32'h8000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1));
		dir_rows.push_back(make_row(ROW_ELEM, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1));
		dir_rows.push_back(make_row(ROW_ELEM, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 1'b1));
		// Size zero acts as one, and the write restarts framing.
		dir_rows.push_back(make_row(ROW_SIZE, 32'd0, 1'b0, 1'b0, '0, 1'b0));
		dir_rows.push_back(make_row(ROW_ELEM, 32'h1234_5678, 1'b1, 1'b0, '0, 1'b0));
		dir_rows.push_back(make_row(ROW_ELEM, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678, 1'b1));
		// Size two: frame 1 2 / 3 4 comes out as 3 1 / 4 2.
		dir_rows.push_back(make_row(ROW_SIZE, 32'd2, 1'b0, 1'b0, '0, 1'b0));
		for (int v = 1; v <= 4; v++)
			dir_rows.push_back(make_row(ROW_ELEM, word_t'(v), 1'b1, 1'b0, '0, 1'b0));
		dir_rows.push_back(make_row(ROW_ELEM, 32'hAAAA_AAAA, 1'b1, 1'b1, 32'd3, 1'b0));
		dir_rows.push_back(make_row(ROW_ELEM, 32'h5555_5555, 1'b1, 1'b1, 32'd1, 1'b0));
		dir_rows.push_back(make_row(ROW_ELEM, 32'h0123_4567, 1'b1, 1'b1, 32'd4, 1'b0));
		dir_rows.push_back(make_row(ROW_ELEM, 32'h89AB_CDEF, 1'b1, 1'b1, 32'd2, 1'b1));
		// Size three: a full frame, then the start of its rotation.
		dir_rows.push_back(make_row(ROW_SIZE, 32'd3, 1'b0, 1'b0, '0, 1'b0));
		for (int v = 0; v < 11; v++)
			dir_rows.push_back(make_row(ROW_ELEM, $urandom(), 1'b0, 1'b0, '0, 1'b0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_SIZE) begin
				write_size(row.data[CFG_SIZE_W-1:0]);
			end else begin
				send_element(row.data, row.typed, row.has_result, row.result);
				if (i + 1 < dir_rows.size() && dir_rows[i + 1].kind == ROW_ELEM)
					pace_sender();
			end
		end

		// The receiver holds off in this phase while the sender keeps offering items.
		run_phase(6'd4, 80, 1'b1);
		// A saturating size starts a full-size frame, so no item comes out yet.
		run_phase(6'd63, 24, 1'b1);

		// Random phases, mostly small sizes; item counts often end mid-frame.
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				sz = CFG_SIZE_W'($urandom_range(0, 12));
			else
				sz = CFG_SIZE_W'($urandom_range(1, 8));
			n = size_side(sz);
			items = n * n * $urandom_range(1, 3) + $urandom_range(0, n * n - 1);
			if (items > RANDOM_ITEMS - random_items)
				items = RANDOM_ITEMS - random_items;
			run_phase(sz, items, 1'b1);
		end

		s_tvalid <= 1'b0;
		while (rotations_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Receiver: changes its stall pattern now and then, and holds off once for long.
	initial begin : receiver
		rx_mode_e    mode;
		int unsigned left;
		mode = RX_OPEN;
		left = 0;
		forever begin
			@(posedge clk);
			if (!held_off && results_seen >= HOLD_TRIGGER) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (left == 0) begin
					mode = rx_mode_e'($urandom_range(0, 3));
					left = $urandom_range(8, 64);
				end
				left--;
				case (mode)
					RX_OPEN:   m_tready <= 1'b1;
					RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= ~m_tready;
				endcase
			end
		end
	end

	// Compares every accepted output item with the oldest expectation.
	always @(posedge clk) begin : check_rotation
		rot_item_t got;
		if (m_tvalid && m_tready) begin
			got.value     = m_tdata;
			got.frame_end = m_tlast;
			results_seen++;
			if (rotations_due.size() == 0) begin
				note_mismatch("Output item with none expected", '0, got);
			end else begin
				if (rotations_due[0].value !== got.value ||
						rotations_due[0].frame_end !== got.frame_end)
					note_mismatch("Output item differs", rotations_due[0], got);
				void'(rotations_due.pop_front());
			end
		end
	end

	// Watchdog: ends the run when no handshake completes for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

/* sim.f */
sv/mr90_pkg.sv
sv/mr90_ram.sv
sv/mr90_front.sv
sv/mr90_queue.sv
sv/matrix_rotate_90_cw.sv
sv/mr90_checker.sv
dv/matrix_rotate_90_cw_tb.sv
